// ===== rtl/snfcs_pkg.sv =====
package snfcs_pkg;

  // Page size in bytes and the counter that tracks bytes sent in one page.
  localparam int PAGE_BYTES = 256;
  localparam int PCOUNT_W   = $clog2(PAGE_BYTES + 1);

  // Most results that one item can cause.
  localparam int MAX_RES = 7;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  localparam int POLL_W        = 20;
  localparam int ADDR_W        = 24;
  localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 20'd500000;

  // Request modes.
  localparam logic [2:0] MODE_READ_ID      = 3'd0;
  localparam logic [2:0] MODE_SECTOR_ERASE = 3'd1;
  localparam logic [2:0] MODE_PROG_BEGIN   = 3'd2;
  localparam logic [2:0] MODE_PROG_BYTE    = 3'd3;
  localparam logic [2:0] MODE_READ_BEGIN   = 3'd4;
  localparam logic [2:0] MODE_READ_NEXT    = 3'd5;
  localparam logic [2:0] MODE_STATUS_REPLY = 3'd6;

  // Sequencer phases.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PROGRAM = 2'd1;
  localparam logic [1:0] PH_READ    = 2'd2;
  localparam logic [1:0] PH_POLL    = 2'd3;

  // Result actions.
  localparam logic [1:0] ACT_SEND    = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_SKIPPED = 2'd2;
  localparam logic [1:0] ACT_TIMEOUT = 2'd3;

  // Flash opcodes.
  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_ERASE  = 8'h20;
  localparam logic [7:0] OP_PROG   = 8'h02;
  localparam logic [7:0] OP_READ   = 8'h03;
  localparam logic [7:0] OP_RDID   = 8'h9F;
  localparam logic [7:0] OP_RDSR   = 8'h05;
  localparam logic [7:0] OP_DUMMY  = 8'hFF;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic [1:0] action;
    logic       select_before;
    logic       release_after;
    logic       awaiting_status;
  } res_t;

  typedef struct packed {
    logic                failed;
    logic [1:0]          phase;
    logic [PCOUNT_W-1:0] program_count;
    logic [POLL_W-1:0]   poll_remaining;
  } seq_state_t;

  function automatic res_t mk_res(logic [7:0] b, logic [1:0] act, logic sel, logic rel,
                                  logic await);
    res_t r;
    r.spi_byte        = b;
    r.action          = act;
    r.select_before   = sel;
    r.release_after   = rel;
    r.awaiting_status = await;
    return r;
  endfunction

endpackage

// ===== rtl/snfcs_decode.sv =====
module snfcs_decode (
  input  logic [2:0]                    mode,
  input  logic [snfcs_pkg::ADDR_W-1:0]  address,
  input  logic [7:0]                    data_byte,
  input  logic                          last,
  input  logic [snfcs_pkg::POLL_W-1:0]  poll_limit,
  input  snfcs_pkg::seq_state_t         cur,
  output snfcs_pkg::seq_state_t         nxt,
  output snfcs_pkg::res_t               res [snfcs_pkg::MAX_RES],
  output logic [snfcs_pkg::CNT_W-1:0]   res_count
);
  import snfcs_pkg::*;

  res_t       blank;
  logic [7:0] a2;
  logic [7:0] a1;
  logic [7:0] a0;

  assign blank = mk_res(8'h00, ACT_SEND, 1'b0, 1'b0, 1'b0);
  assign a2    = address[23:16];
  assign a1    = address[15:8];
  assign a0    = address[7:0];

  always_comb begin
    nxt       = cur;
    res_count = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = blank;
    end

    if (cur.failed) begin
      res[0]    = mk_res(8'h00, ACT_SKIPPED, 1'b0, 1'b0, 1'b0);
      res_count = CNT_W'(1);
    end else begin
      case (mode)
        MODE_READ_ID: begin
          if (cur.phase == PH_IDLE) begin
            res[0]    = mk_res(OP_RDID, ACT_SEND, 1'b1, 1'b0, 1'b0);
            res[1]    = mk_res(OP_DUMMY, ACT_SEND, 1'b0, 1'b0, 1'b0);
            res[2]    = mk_res(OP_DUMMY, ACT_SEND, 1'b0, 1'b1, 1'b0);
            res_count = CNT_W'(3);
          end
        end
        MODE_SECTOR_ERASE: begin
          if (cur.phase == PH_IDLE) begin
            res[0]             = mk_res(OP_WREN, ACT_SEND, 1'b1, 1'b1, 1'b0);
            res[1]             = mk_res(OP_ERASE, ACT_SEND, 1'b1, 1'b0, 1'b0);
            res[2]             = mk_res(a2, ACT_SEND, 1'b0, 1'b0, 1'b0);
            res[3]             = mk_res(a1, ACT_SEND, 1'b0, 1'b0, 1'b0);
            res[4]             = mk_res(a0, ACT_SEND, 1'b0, 1'b1, 1'b0);
            res[5]             = mk_res(OP_RDSR, ACT_SEND, 1'b1, 1'b0, 1'b0);
            res[6]             = mk_res(OP_DUMMY, ACT_SEND, 1'b0, 1'b0, 1'b1);
            res_count          = CNT_W'(7);
            nxt.poll_remaining = poll_limit;
            nxt.phase          = PH_POLL;
          end
        end
        MODE_PROG_BEGIN: begin
          if (cur.phase == PH_IDLE) begin
            res[0]            = mk_res(OP_WREN, ACT_SEND, 1'b1, 1'b1, 1'b0);
            res[1]            = mk_res(OP_PROG, ACT_SEND, 1'b1, 1'b0, 1'b0);
            res[2]            = mk_res(a2, ACT_SEND, 1'b0, 1'b0, 1'b0);
            res[3]            = mk_res(a1, ACT_SEND, 1'b0, 1'b0, 1'b0);
            res[4]            = mk_res(a0, ACT_SEND, 1'b0, last, 1'b0);
            nxt.program_count = '0;
            if (last) begin
              res[5]             = mk_res(OP_RDSR, ACT_SEND, 1'b1, 1'b0, 1'b0);
              res[6]             = mk_res(OP_DUMMY, ACT_SEND, 1'b0, 1'b0, 1'b1);
              res_count          = CNT_W'(7);
              nxt.poll_remaining = poll_limit;
              nxt.phase          = PH_POLL;
            end else begin
              res_count = CNT_W'(5);
              nxt.phase = PH_PROGRAM;
            end
          end
        end
        MODE_PROG_BYTE: begin
          if (cur.phase == PH_PROGRAM) begin
            // Bytes beyond the page are dropped; a dropped last byte still
            // closes the frame with a release-only result.
            if (cur.program_count < PCOUNT_W'(PAGE_BYTES)) begin
              res[0]            = mk_res(data_byte, ACT_SEND, 1'b0, last, 1'b0);
              nxt.program_count = cur.program_count + PCOUNT_W'(1);
              res_count         = CNT_W'(1);
            end else if (last) begin
              res[0]    = mk_res(8'h00, ACT_RELEASE, 1'b0, 1'b1, 1'b0);
              res_count = CNT_W'(1);
            end
            if (last) begin
              res[1]             = mk_res(OP_RDSR, ACT_SEND, 1'b1, 1'b0, 1'b0);
              res[2]             = mk_res(OP_DUMMY, ACT_SEND, 1'b0, 1'b0, 1'b1);
              res_count          = CNT_W'(3);
              nxt.poll_remaining = poll_limit;
              nxt.phase          = PH_POLL;
            end
          end
        end
        MODE_READ_BEGIN: begin
          if (cur.phase == PH_IDLE) begin
            res[0]    = mk_res(OP_READ, ACT_SEND, 1'b1, 1'b0, 1'b0);
            res[1]    = mk_res(a2, ACT_SEND, 1'b0, 1'b0, 1'b0);
            res[2]    = mk_res(a1, ACT_SEND, 1'b0, 1'b0, 1'b0);
            res[3]    = mk_res(a0, ACT_SEND, 1'b0, last, 1'b0);
            res_count = CNT_W'(4);
            nxt.phase = last ? PH_IDLE : PH_READ;
          end
        end
        MODE_READ_NEXT: begin
          if (cur.phase == PH_READ) begin
            res[0]    = mk_res(OP_DUMMY, ACT_SEND, 1'b0, last, 1'b0);
            res_count = CNT_W'(1);
            if (last) begin
              nxt.phase = PH_IDLE;
            end
          end
        end
        MODE_STATUS_REPLY: begin
          if (cur.phase == PH_POLL) begin
            res_count = CNT_W'(1);
            if (!data_byte[0]) begin
              res[0]    = mk_res(8'h00, ACT_RELEASE, 1'b0, 1'b1, 1'b0);
              nxt.phase = PH_IDLE;
            end else if (cur.poll_remaining <= POLL_W'(1)) begin
              res[0]             = mk_res(8'h00, ACT_TIMEOUT, 1'b0, 1'b1, 1'b0);
              nxt.poll_remaining = '0;
              nxt.failed         = 1'b1;
              nxt.phase          = PH_IDLE;
            end else begin
              res[0]             = mk_res(OP_DUMMY, ACT_SEND, 1'b0, 1'b0, 1'b1);
              nxt.poll_remaining = cur.poll_remaining - POLL_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/spi_nor_flash_command_sequencer.sv =====
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  request item: mode, address, data byte, last
// m_*       out        m_tvalid/m_tready  result item: SPI byte, action, framing flags
// APB       in         psel/penable       poll_limit register at byte address 0
//
// An accepted item is decoded in the cycle it arrives and its results (up to
// seven) are loaded into a result queue, which sends one result per cycle while
// m_tready is high; the result queue and its single output port set the rate.
// A new item is taken when the queue is empty or its final result leaves.
// Reset is synchronous and restores the idle, non-failed state.
module spi_nor_flash_command_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [23:0] address, [31:24] data_byte
  input  logic [2:0]  s_tuser,   // [2:0] mode
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] spi_byte, [8] select_before,
                                 // [9] release_after, [10] awaiting_status, rest zero
  output logic [1:0]  m_tuser,   // [1:0] action
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import snfcs_pkg::*;

  logic [POLL_W-1:0] poll_limit;
  seq_state_t        state;
  seq_state_t        state_next;
  res_t              dec_res [MAX_RES];
  logic [CNT_W-1:0]  dec_count;
  res_t              queue [MAX_RES];
  logic [CNT_W-1:0]  count;
  logic              in_fire;
  logic              out_fire;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == 3'd0);
  assign prdata    = (paddr == 3'd0) ? {{(32 - POLL_W){1'b0}}, poll_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= POLL_LIMIT_RST;
    end else if (cfg_write) begin
      poll_limit <= pwdata[POLL_W-1:0];
    end
  end

  snfcs_decode u_decode (
    .mode      (s_tuser),
    .address   (s_tdata[23:0]),
    .data_byte (s_tdata[31:24]),
    .last      (s_tlast),
    .poll_limit(poll_limit),
    .cur       (state),
    .nxt       (state_next),
    .res       (dec_res),
    .res_count (dec_count)
  );

  assign m_tvalid = (count != '0);
  assign out_fire = m_tvalid && m_tready;
  assign s_tready = (count == '0) || ((count == CNT_W'(1)) && m_tready);
  assign in_fire  = s_tvalid && s_tready;

  assign m_tdata = {5'd0, queue[0].awaiting_status, queue[0].release_after,
                    queue[0].select_before, queue[0].spi_byte};
  assign m_tuser = queue[0].action;
  assign m_tlast = (count == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state.failed         <= 1'b0;
      state.phase          <= PH_IDLE;
      state.program_count  <= '0;
      state.poll_remaining <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= dec_count;
    end else if (out_fire) begin
      count <= count - CNT_W'(1);
    end
  end

  // Queue payload: a new item loads all slots, otherwise each sent result
  // moves the rest down one place.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RES; i++) begin
        queue[i] <= dec_res[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        queue[i] <= queue[i + 1];
      end
    end
  end

endmodule
